[hdl/iibm_pkg.sv]
// ----------------------------------------------------------------------------
// iibm_pkg
// Shared widths, types and the divider step for the interleave block mapper.
// ----------------------------------------------------------------------------
package iibm_pkg;

  localparam int SECTOR_BYTES = 512;
  localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);

  localparam int BLK_W  = 23;
  localparam int LBS_W  = 12;
  localparam int BSZ_W  = 14;
  localparam int FUB_W  = 8;
  localparam int EXT_W  = 32;
  localparam int PROD_W = BLK_W + BSZ_W;
  localparam int BASE_W = PROD_W + 1;
  localparam int MUL_W  = BASE_W + FUB_W + 1;
  localparam int LBN_W  = MUL_W + 1;
  localparam int HALF_W = LBN_W / 2;
  localparam int PART_W = HALF_W + LBS_W;
  localparam int ADDR_W = LBN_W + LBS_W;
  localparam int BN_W   = ADDR_W - SECTOR_SHIFT;
  localparam int LEFT_W = FUB_W + LBS_W;
  localparam int REM_W  = 16;
  localparam int SEC_W  = 34;
  localparam int OIB_W  = 13;

  typedef enum logic [2:0] {
    REG_LBS    = 3'd0,
    REG_VBS    = 3'd1,
    REG_BUF    = 3'd2,
    REG_FUB    = 3'd3,
    REG_GAP    = 3'd4,
    REG_XAR    = 3'd5,
    REG_EXTENT = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [LBS_W-1:0] logical_block_size;
    logic [BSZ_W-1:0] volume_block_size;
    logic [BSZ_W-1:0] buffer_size;
    logic [FUB_W-1:0] file_unit_blocks;
    logic [FUB_W-1:0] interleave_gap_blocks;
    logic [FUB_W-1:0] xar_blocks;
    logic [EXT_W-1:0] extent_start;
  } cfg_t;

  typedef struct packed {
    logic             cmd;
    logic [BLK_W-1:0] block_number;
  } req_t;

  typedef struct packed {
    logic [SEC_W-1:0] disk_sector;
    logic [BSZ_W-1:0] data_in_buf;
    logic [OIB_W-1:0] offset_in_buf;
    logic             remap_error;
  } res_t;

  function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] rem,
                                               input logic din,
                                               input logic [REM_W-1:0] dvs);
    logic [REM_W:0] trial;
    logic [REM_W:0] diff;
    trial = {rem, din};
    diff  = trial - {1'b0, dvs};
    if (trial >= {1'b0, dvs}) begin
      return {1'b1, diff[REM_W-1:0]};
    end
    return {1'b0, trial[REM_W-1:0]};
  endfunction

endpackage

[hdl/iibm_scale.sv]
// ----------------------------------------------------------------------------
// iibm_scale
// Scales volume-block requests to logical blocks and adds the XAR length.
// ----------------------------------------------------------------------------
module iibm_scale import iibm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              in_valid,
  input  req_t              req,
  output logic              out_valid,
  output logic              out_cmd,
  output logic [BASE_W-1:0] base_bn
);

  logic             sv [0:PROD_W];
  logic             sc [0:PROD_W];
  logic [BLK_W-1:0] sb [0:PROD_W];
  logic [REM_W-1:0] sr [0:PROD_W];
  logic [PROD_W-1:0] sq [0:PROD_W];
  logic [BASE_W-1:0] quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else begin
      sv[0] <= in_valid;
    end
    sc[0] <= req.cmd;
    sb[0] <= req.block_number;
    sr[0] <= '0;
    sq[0] <= PROD_W'(req.block_number) * PROD_W'(cfg.volume_block_size);
  end

  for (genvar i = 0; i < PROD_W; i++) begin : g_div
    logic [REM_W:0] st;
    assign st = div_step(sr[i], sq[i][PROD_W-1], REM_W'(cfg.logical_block_size));
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[i+1] <= 1'b0;
      end else begin
        sv[i+1] <= sv[i];
      end
      sc[i+1] <= sc[i];
      sb[i+1] <= sb[i];
      sr[i+1] <= st[REM_W-1:0];
      sq[i+1] <= {sq[i][PROD_W-2:0], st[REM_W]};
    end
  end

  always_comb begin
    if (sc[PROD_W]) begin
      quot = BASE_W'(sb[PROD_W]);
    end else if (cfg.logical_block_size != '0) begin
      quot = BASE_W'(sq[PROD_W]);
    end else begin
      quot = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= sv[PROD_W];
    end
    out_cmd <= sc[PROD_W];
    base_bn <= quot + BASE_W'(cfg.xar_blocks);
  end

endmodule

[hdl/iibm_leave.sv]
// ----------------------------------------------------------------------------
// iibm_leave
// Maps a logical block through file units and gaps and forms the sector.
// ----------------------------------------------------------------------------
module iibm_leave import iibm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              in_valid,
  input  logic              in_cmd,
  input  logic [BASE_W-1:0] base_bn,
  output logic              out_valid,
  output logic              out_cmd,
  output logic [BN_W-1:0]   bn,
  output logic [BSZ_W-1:0]  dib
);

  logic              sv [0:BASE_W];
  logic              sc [0:BASE_W];
  logic [BASE_W-1:0] sb [0:BASE_W];
  logic [REM_W-1:0]  sr [0:BASE_W];
  logic [BASE_W-1:0] sq [0:BASE_W];

  logic              m_valid, m_cmd;
  logic [BASE_W-1:0] m_base;
  logic [FUB_W-1:0]  m_within;
  logic [MUL_W-1:0]  m_prod;
  logic [LEFT_W-1:0] m_left;

  logic              e_valid, e_cmd;
  logic [LBN_W-1:0]  e_lbn;
  logic [BSZ_W-1:0]  e_dib;

  logic              x_valid, x_cmd;
  logic [PART_W-1:0] x_lo, x_hi;
  logic [BSZ_W-1:0]  x_dib;

  logic              leave_on;
  logic [BSZ_W-1:0]  m_bsize;
  logic [FUB_W-1:0]  unit_ofs;
  logic [ADDR_W-1:0] full;

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else begin
      sv[0] <= in_valid;
    end
    sc[0] <= in_cmd;
    sb[0] <= base_bn;
    sr[0] <= '0;
    sq[0] <= base_bn;
  end

  for (genvar i = 0; i < BASE_W; i++) begin : g_div
    logic [REM_W:0] st;
    assign st = div_step(sr[i], sq[i][BASE_W-1], REM_W'(cfg.file_unit_blocks));
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[i+1] <= 1'b0;
      end else begin
        sv[i+1] <= sv[i];
      end
      sc[i+1] <= sc[i];
      sb[i+1] <= sb[i];
      sr[i+1] <= st[REM_W-1:0];
      sq[i+1] <= {sq[i][BASE_W-2:0], st[REM_W]};
    end
  end

  assign unit_ofs = sr[BASE_W][FUB_W-1:0];
  assign leave_on = (cfg.file_unit_blocks != '0) && (cfg.logical_block_size != '0);
  assign m_bsize  = m_cmd ? cfg.buffer_size : cfg.volume_block_size;
  assign full     = ADDR_W'(x_lo) + (ADDR_W'(x_hi) << HALF_W);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid   <= 1'b0;
      e_valid   <= 1'b0;
      x_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      m_valid   <= sv[BASE_W];
      e_valid   <= m_valid;
      x_valid   <= e_valid;
      out_valid <= x_valid;
    end
    m_cmd    <= sc[BASE_W];
    m_base   <= sb[BASE_W];
    m_within <= unit_ofs;
    m_prod   <= MUL_W'(sq[BASE_W]) *
                MUL_W'({1'b0, cfg.file_unit_blocks} + {1'b0, cfg.interleave_gap_blocks});
    m_left   <= LEFT_W'(cfg.file_unit_blocks - unit_ofs) * LEFT_W'(cfg.logical_block_size);

    e_cmd <= m_cmd;
    if (leave_on) begin
      e_lbn <= LBN_W'(m_prod) + LBN_W'(m_within) + LBN_W'(cfg.extent_start);
      e_dib <= (m_left < LEFT_W'(m_bsize)) ? BSZ_W'(m_left) : m_bsize;
    end else begin
      e_lbn <= LBN_W'(m_base) + LBN_W'(cfg.extent_start);
      e_dib <= m_bsize;
    end

    x_cmd <= e_cmd;
    x_dib <= e_dib;
    x_lo  <= PART_W'(e_lbn[HALF_W-1:0]) * PART_W'(cfg.logical_block_size);
    x_hi  <= PART_W'(e_lbn[LBN_W-1:HALF_W]) * PART_W'(cfg.logical_block_size);

    out_cmd <= x_cmd;
    dib     <= x_dib;
    bn      <= full[ADDR_W-1:SECTOR_SHIFT];
  end

endmodule

[hdl/iibm_align.sv]
// ----------------------------------------------------------------------------
// iibm_align
// Aligns internal requests down to a buffer boundary and trims the data count.
// ----------------------------------------------------------------------------
module iibm_align import iibm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             in_valid,
  input  logic             in_cmd,
  input  logic [BN_W-1:0]  in_bn,
  input  logic [BSZ_W-1:0] in_dib,
  output logic             out_valid,
  output res_t             res
);

  logic              sv [0:ADDR_W];
  logic              sc [0:ADDR_W];
  logic [BN_W-1:0]   sb [0:ADDR_W];
  logic [BSZ_W-1:0]  sd [0:ADDR_W];
  logic [REM_W-1:0]  sr [0:ADDR_W];
  logic [ADDR_W-1:0] sq [0:ADDR_W];

  logic [REM_W-1:0] oib, neg_oib, oib_up;
  logic             align, err, fit;
  logic [BN_W-1:0]  bn_adj;
  res_t             res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else begin
      sv[0] <= in_valid;
    end
    sc[0] <= in_cmd;
    sb[0] <= in_bn;
    sd[0] <= in_dib;
    sr[0] <= '0;
    sq[0] <= {in_bn, SECTOR_SHIFT'(0)};
  end

  for (genvar i = 0; i < ADDR_W; i++) begin : g_div
    logic [REM_W:0] st;
    assign st = div_step(sr[i], sq[i][ADDR_W-1], REM_W'(cfg.buffer_size));
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[i+1] <= 1'b0;
      end else begin
        sv[i+1] <= sv[i];
      end
      sc[i+1] <= sc[i];
      sb[i+1] <= sb[i];
      sd[i+1] <= sd[i];
      sr[i+1] <= st[REM_W-1:0];
      sq[i+1] <= {sq[i][ADDR_W-2:0], 1'b0};
    end
  end

  always_comb begin
    oib     = sr[ADDR_W];
    neg_oib = REM_W'(0) - oib;
    oib_up  = oib + REM_W'(neg_oib[SECTOR_SHIFT-1:0]);
    align   = sc[ADDR_W] && (cfg.buffer_size != '0) && (oib != '0);
    err     = REM_W'(cfg.buffer_size) < oib_up;
    fit     = (REM_W'(oib_up) + REM_W'(sd[ADDR_W])) > REM_W'(cfg.buffer_size);
    bn_adj  = sb[ADDR_W] - BN_W'(oib_up >> SECTOR_SHIFT);

    res_next.disk_sector   = sb[ADDR_W][SEC_W-1:0];
    res_next.data_in_buf   = sd[ADDR_W];
    res_next.offset_in_buf = '0;
    res_next.remap_error   = 1'b0;
    if (align) begin
      res_next.offset_in_buf = oib[OIB_W-1:0];
      if (err) begin
        res_next.disk_sector = '0;
        res_next.remap_error = 1'b1;
      end else begin
        res_next.disk_sector = bn_adj[SEC_W-1:0];
        if (fit) begin
          res_next.data_in_buf = BSZ_W'(REM_W'(cfg.buffer_size) - oib_up);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= sv[ADDR_W];
    end
    res <= res_next;
  end

endmodule

[hdl/iso9660_interleave_block_mapper.sv]
// ----------------------------------------------------------------------------
// iso9660_interleave_block_mapper
// Maps a file block number to a disk sector for an interleaved ISO 9660 file.
//
// Requests: req (cmd, block_number) transfers on a clock edge with start high
// and busy low. busy stays low, so a request may be issued every cycle.
// Results: res is valid while done is high, in request order, one per request.
// The receiver cannot stall the block.
// Throughput is one request per clock; each request passes through three
// bit-serial divider pipelines (scale by logical block size, split into file
// units, remainder against the buffer size), one register stage per quotient
// bit, plus the multiply and add stages between them.
// Configuration: cfg_index/cfg_data transfer when cfg_valid and cfg_ready are
// high; cfg_ready stays high. Write registers only with no request in flight.
// Reset: rst clears all stage valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module iso9660_interleave_block_mapper import iibm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_t        req,
  output logic        done,
  output res_t        res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t              cfg;
  logic              s_valid, s_cmd;
  logic [BASE_W-1:0] s_base;
  logic              l_valid, l_cmd;
  logic [BN_W-1:0]   l_bn;
  logic [BSZ_W-1:0]  l_dib;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.logical_block_size    <= LBS_W'(2048);
      cfg.volume_block_size     <= BSZ_W'(2048);
      cfg.buffer_size           <= BSZ_W'(8192);
      cfg.file_unit_blocks      <= '0;
      cfg.interleave_gap_blocks <= '0;
      cfg.xar_blocks            <= '0;
      cfg.extent_start          <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LBS:    cfg.logical_block_size    <= cfg_data[LBS_W-1:0];
        REG_VBS:    cfg.volume_block_size     <= cfg_data[BSZ_W-1:0];
        REG_BUF:    cfg.buffer_size           <= cfg_data[BSZ_W-1:0];
        REG_FUB:    cfg.file_unit_blocks      <= cfg_data[FUB_W-1:0];
        REG_GAP:    cfg.interleave_gap_blocks <= cfg_data[FUB_W-1:0];
        REG_XAR:    cfg.xar_blocks            <= cfg_data[FUB_W-1:0];
        REG_EXTENT: cfg.extent_start          <= cfg_data[EXT_W-1:0];
        default: ;
      endcase
    end
  end

  iibm_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (start && !busy),
    .req       (req),
    .out_valid (s_valid),
    .out_cmd   (s_cmd),
    .base_bn   (s_base)
  );

  iibm_leave u_leave (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_valid),
    .in_cmd    (s_cmd),
    .base_bn   (s_base),
    .out_valid (l_valid),
    .out_cmd   (l_cmd),
    .bn        (l_bn),
    .dib       (l_dib)
  );

  iibm_align u_align (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (l_valid),
    .in_cmd    (l_cmd),
    .in_bn     (l_bn),
    .in_dib    (l_dib),
    .out_valid (done),
    .res       (res)
  );

endmodule

[bench/iso9660_interleave_block_mapper_chk.sv]
// ----------------------------------------------------------------------------
// iso9660_interleave_block_mapper_chk
// Watches the request, result and configuration channels of the block mapper,
// predicts each mapped sector in request order and counts mismatches.
// ----------------------------------------------------------------------------
module iso9660_interleave_block_mapper_chk import iibm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  req_t        req,
  input  logic        done,
  input  res_t        res,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending,
  output int          mapped
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t map_cfg;
  res_t sector_q[$];

  function automatic res_t map_block(input cfg_t c, input req_t r);
    logic [127:0] blk, lbs, bsize, base_bn, lbn, dib, oib, bn, addr;
    logic [127:0] unit_no, blk_in_unit, left, span_end, first, limit, fub;
    res_t o;
    blk = r.block_number;
    lbs = c.logical_block_size;
    fub = c.file_unit_blocks;
    bsize = r.cmd ? c.buffer_size : c.volume_block_size;
    oib = 0;
    o.remap_error = 1'b0;
    if (!r.cmd) begin
      blk = (lbs != 0) ? (blk * c.volume_block_size) / lbs : 0;
    end
    base_bn = blk + c.xar_blocks;
    dib = bsize;
    if (fub != 0 && lbs != 0) begin
      unit_no = base_bn / fub;
      blk_in_unit = base_bn % fub;
      left = (fub - blk_in_unit) * lbs;
      lbn = blk_in_unit + unit_no * (fub + c.interleave_gap_blocks);
      dib = (left < bsize) ? left : bsize;
    end else begin
      lbn = base_bn;
    end
    lbn = lbn + c.extent_start;
    bn = (lbn * lbs) / SECTOR_BYTES;
    addr = bn * SECTOR_BYTES;
    if (r.cmd && bsize != 0 && (addr % bsize) != 0) begin
      span_end = addr + dib;
      oib = addr % bsize;
      bn = (addr - oib) / SECTOR_BYTES;
      first = bn * SECTOR_BYTES;
      limit = first + bsize;
      if (limit < addr) begin
        o.remap_error = 1'b1;
        bn = 0;
      end else if (limit < span_end) begin
        dib = dib - (span_end - limit);
      end
    end
    o.disk_sector = bn[SEC_W-1:0];
    o.data_in_buf = dib[BSZ_W-1:0];
    o.offset_in_buf = oib[OIB_W-1:0];
    return o;
  endfunction

  assign pending = sector_q.size();

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      map_cfg <= '{12'd2048, 14'd2048, 14'd8192, 8'd0, 8'd0, 8'd0, 32'd0};
      sector_q.delete();
      errors <= 0;
      mapped <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_LBS:    map_cfg.logical_block_size <= cfg_data[LBS_W-1:0];
          REG_VBS:    map_cfg.volume_block_size <= cfg_data[BSZ_W-1:0];
          REG_BUF:    map_cfg.buffer_size <= cfg_data[BSZ_W-1:0];
          REG_FUB:    map_cfg.file_unit_blocks <= cfg_data[FUB_W-1:0];
          REG_GAP:    map_cfg.interleave_gap_blocks <= cfg_data[FUB_W-1:0];
          REG_XAR:    map_cfg.xar_blocks <= cfg_data[FUB_W-1:0];
          REG_EXTENT: map_cfg.extent_start <= cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) sector_q.push_back(map_block(map_cfg, req));
      if (done) begin
        mapped <= mapped + 1;
        if (sector_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, res);
          errors <= errors + 1;
        end else begin
          want = sector_q.pop_front();
          if (want !== res) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, res);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

[bench/iso9660_interleave_block_mapper_tb.sv]
// ----------------------------------------------------------------------------
// iso9660_interleave_block_mapper_tb
// Drives directed and random map requests across several register settings,
// including the extremes, in random bursts; the checker compares each result.
// ----------------------------------------------------------------------------
module iso9660_interleave_block_mapper_tb import iibm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 144;
  localparam int WATCHDOG = 20000;

  logic clk = 1'b0, rst = 1'b1, start = 1'b0, cfg_valid = 1'b0;
  logic busy, done, cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  req_t req = '0;
  res_t res;
  int errors, pending, mapped, idle_cycles, requests;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  iso9660_interleave_block_mapper dut (.*);
  iso9660_interleave_block_mapper_chk chk (.*);

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("FAIL iso9660_interleave_block_mapper");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 8) @(negedge clk);
  endtask

  task automatic send_map(input logic cmd, input logic [BLK_W-1:0] blk);
    start <= 1'b1;
    req <= '{cmd, blk};
    do @(posedge clk); while (busy);
    @(negedge clk);
    requests++;
  endtask

  task automatic random_burst(input int n);
    int left;
    left = n;
    while (left > 0) begin
      int len;
      len = $urandom_range(1, 20);
      for (int i = 0; i < len && left > 0; i++, left--) begin
        case ($urandom_range(0, 3))
          0: send_map(1'($urandom_range(0, 1)), BLK_W'($urandom()));
          1: send_map(1'($urandom_range(0, 1)), BLK_W'($urandom_range(0, 300)));
          2: send_map(1'($urandom_range(0, 1)),
                      BLK_W'(2**BLK_W - 1 - $urandom_range(0, 3)));
          default: send_map(1'($urandom_range(0, 1)), BLK_W'($urandom_range(0, 70000)));
        endcase
      end
      start <= 1'b0;
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    start <= 1'b0;
  endtask

  task automatic random_config;
    write_reg(REG_LBS, $urandom_range(0, 7) == 0 ? $urandom() : 512 << $urandom_range(0, 2));
    write_reg(REG_VBS, $urandom_range(0, 7) == 0 ? $urandom() : 512 << $urandom_range(0, 4));
    write_reg(REG_BUF, $urandom_range(0, 7) == 0 ? $urandom() : 512 << $urandom_range(0, 4));
    write_reg(REG_FUB, $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 255));
    write_reg(REG_GAP, $urandom_range(0, 255));
    write_reg(REG_XAR, $urandom_range(0, 255));
    write_reg(REG_EXTENT, $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 100000));
  endtask

  initial begin
    requests = 0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // defaults first, then directed extremes
    send_map(1'b0, '0);
    send_map(1'b1, '1);
    send_map(1'b0, '1);
    send_map(1'b1, 23'd3);
    start <= 1'b0;
    drain();
    write_reg(REG_LBS, 512);
    write_reg(REG_VBS, 8192);
    write_reg(REG_BUF, 8192);
    write_reg(REG_FUB, 255);
    write_reg(REG_GAP, 255);
    write_reg(REG_XAR, 255);
    write_reg(REG_EXTENT, 32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++) send_map(i[0], i < 2 ? '0 : (i < 4 ? '1 : 23'd254));
    start <= 1'b0;
    drain();
    write_reg(REG_LBS, 0);
    write_reg(REG_BUF, 0);
    write_reg(REG_FUB, 3);
    write_reg(REG_GAP, 0);
    write_reg(REG_XAR, 0);
    write_reg(REG_EXTENT, 1);
    send_map(1'b0, 23'd5);
    send_map(1'b1, 23'd5);
    start <= 1'b0;
    drain();
    write_reg(REG_LBS, 2048);
    write_reg(REG_VBS, 512);
    write_reg(REG_BUF, 16383);
    write_reg(REG_FUB, 1);
    write_reg(REG_EXTENT, 7);
    for (int i = 0; i < 8; i++) send_map(i[0], 23'(i * 3));
    start <= 1'b0;
    drain();
    for (int p = 0; p < 10; p++) begin
      random_config();
      random_burst(75);
      drain();
    end
    $display("Mapped %0d requests over 10 random register settings plus directed corners.",
             requests);
    if (errors == 0) $display("PASS iso9660_interleave_block_mapper");
    else $display("FAIL iso9660_interleave_block_mapper");
    $finish;
  end
endmodule

[files.f]
hdl/iibm_pkg.sv
hdl/iibm_scale.sv
hdl/iibm_leave.sv
hdl/iibm_align.sv
hdl/iso9660_interleave_block_mapper.sv
bench/iso9660_interleave_block_mapper_chk.sv
bench/iso9660_interleave_block_mapper_tb.sv
